/* src/assert_macros.svh */
// Assertion helpers used by the parser unit RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/jhdp_pkg.sv */
package jhdp_pkg;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_MARKHI,
    PH_MARKLO,
    PH_LENHI,
    PH_LENLO,
    PH_PAYLOAD,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SOI,
    ST_MALFORMED,
    ST_TRUNCATED
  } status_e;

  localparam logic [7:0]  SoiByte0     = 8'hFF;
  localparam logic [7:0]  SoiByte1     = 8'hD8;
  localparam logic [15:0] SofFirst     = 16'hFFC0;
  localparam logic [15:0] SofLast      = 16'hFFCF;
  localparam logic [15:0] DhtMarker    = 16'hFFC4;
  localparam logic [15:0] JpgMarker    = 16'hFFC8;
  localparam logic [15:0] MinLength    = 16'd2;
  localparam logic [15:0] MinSofLength = 16'd7;
  localparam logic [2:0]  PosSat       = 3'd5;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] marker;
    logic [15:0] remain;
    logic [2:0]  pos;
    logic [15:0] height;
    logic [15:0] width;
    logic        found;
    status_e     err;
    logic        frame;
    logic [15:0] pend_h;
    logic [15:0] pend_w;
  } state_t;

  localparam state_t StateReset = '{
    phase:  PH_START0,
    marker: 16'd0,
    remain: 16'd0,
    pos:    3'd0,
    height: 16'd0,
    width:  16'd0,
    found:  1'b0,
    err:    ST_OK,
    frame:  1'b0,
    pend_h: 16'd0,
    pend_w: 16'd0
  };

  function automatic logic is_frame_marker(input logic [15:0] m);
    return (m >= SofFirst) && (m <= SofLast) && (m != DhtMarker) && (m != JpgMarker);
  endfunction

endpackage

/* src/jhdp_step.sv */
module jhdp_step (
  input  jhdp_pkg::state_t  cur_i,
  input  logic [7:0]        byte_i,
  output jhdp_pkg::state_t  nxt_o,
  output jhdp_pkg::status_e status_o
);

  jhdp_pkg::status_e end_st;
  logic [15:0]       len;
  logic [15:0]       rem_len;
  logic [15:0]       rem_dec;
  logic              seg_frame;

  assign len       = {cur_i.remain[15:8], byte_i};
  assign rem_len   = len - jhdp_pkg::MinLength;
  assign rem_dec   = cur_i.remain - 16'd1;
  assign seg_frame = jhdp_pkg::is_frame_marker(cur_i.marker);

  always_comb begin
    nxt_o  = cur_i;
    end_st = jhdp_pkg::ST_OK;
    unique case (cur_i.phase)
      jhdp_pkg::PH_START0: begin
        if (byte_i != jhdp_pkg::SoiByte0) begin
          nxt_o.err   = jhdp_pkg::ST_NO_SOI;
          nxt_o.phase = jhdp_pkg::PH_STOP;
        end else begin
          nxt_o.phase = jhdp_pkg::PH_START1;
          end_st      = jhdp_pkg::ST_NO_SOI;
        end
      end
      jhdp_pkg::PH_START1: begin
        if (byte_i != jhdp_pkg::SoiByte1) begin
          nxt_o.err   = jhdp_pkg::ST_NO_SOI;
          nxt_o.phase = jhdp_pkg::PH_STOP;
        end else begin
          nxt_o.phase = jhdp_pkg::PH_MARKHI;
        end
      end
      jhdp_pkg::PH_MARKHI: begin
        nxt_o.marker = {byte_i, 8'd0};
        nxt_o.phase  = jhdp_pkg::PH_MARKLO;
        end_st       = jhdp_pkg::ST_TRUNCATED;
      end
      jhdp_pkg::PH_MARKLO: begin
        nxt_o.marker = {cur_i.marker[15:8], byte_i};
        nxt_o.phase  = jhdp_pkg::PH_LENHI;
        end_st       = jhdp_pkg::ST_TRUNCATED;
      end
      jhdp_pkg::PH_LENHI: begin
        nxt_o.remain = {byte_i, 8'd0};
        nxt_o.phase  = jhdp_pkg::PH_LENLO;
        end_st       = jhdp_pkg::ST_TRUNCATED;
      end
      jhdp_pkg::PH_LENLO: begin
        nxt_o.frame = seg_frame;
        if ((len < jhdp_pkg::MinLength) || (seg_frame && (len < jhdp_pkg::MinSofLength))) begin
          nxt_o.err   = jhdp_pkg::ST_MALFORMED;
          nxt_o.phase = jhdp_pkg::PH_STOP;
        end else begin
          nxt_o.remain = rem_len;
          nxt_o.pos    = 3'd0;
          if (rem_len == 16'd0) begin
            nxt_o.phase = jhdp_pkg::PH_MARKHI;
          end else begin
            nxt_o.phase = jhdp_pkg::PH_PAYLOAD;
            if (seg_frame) begin
              end_st = jhdp_pkg::ST_TRUNCATED;
            end
          end
        end
      end
      jhdp_pkg::PH_PAYLOAD: begin
        if (cur_i.frame && (cur_i.pos < jhdp_pkg::PosSat)) begin
          case (cur_i.pos)
            3'd1: nxt_o.pend_h = {byte_i, 8'd0};
            3'd2: nxt_o.pend_h = {cur_i.pend_h[15:8], byte_i};
            3'd3: nxt_o.pend_w = {byte_i, 8'd0};
            3'd4: begin
              nxt_o.pend_w = {cur_i.pend_w[15:8], byte_i};
              nxt_o.height = cur_i.pend_h;
              nxt_o.width  = {cur_i.pend_w[15:8], byte_i};
              nxt_o.found  = 1'b1;
            end
            default: ;
          endcase
          if (cur_i.pos < 3'd4) begin
            end_st = jhdp_pkg::ST_TRUNCATED;
          end
        end
        if (cur_i.pos < jhdp_pkg::PosSat) begin
          nxt_o.pos = cur_i.pos + 3'd1;
        end
        nxt_o.remain = rem_dec;
        if (rem_dec == 16'd0) begin
          nxt_o.phase = jhdp_pkg::PH_MARKHI;
        end
      end
      default: ;
    endcase
  end

  assign status_o = (nxt_o.err != jhdp_pkg::ST_OK) ? nxt_o.err : end_st;

endmodule

/* src/jpeg_header_dimension_parser_unit.sv */
// JPEG frame dimension parser.
// Input channel: one stream byte per item (data_byte_i, last_i) on in_valid_i
// and in_ready_o. The parser checks the FF D8 start marker, walks the marker
// segments and picks height and width out of every start-of-frame segment.
// Output channel: one item (height_o, width_o, frame_found_o, status_o) on
// out_valid_o and out_ready_i, produced only for the byte flagged last.
// Status: 0 ok, 1 no start marker, 2 malformed segment, 3 truncated header.
// Throughput is one byte per cycle while no result item is stalled: the state
// update is a single pass of logic from the state register into itself.
// Latency: the result item is valid in the cycle after the last byte is
// accepted, held in the output register.
// A stalled receiver holds the result; input stays open while the output
// register is empty or being drained in the same cycle.
// After a last byte the parser returns to its reset state for a new stream.
// Reset empties the output register and restarts the marker search.
`include "assert_macros.svh"

module jpeg_header_dimension_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] height_o,
  output logic [15:0] width_o,
  output logic        frame_found_o,
  output logic [1:0]  status_o
);

  jhdp_pkg::state_t  state_q;
  jhdp_pkg::state_t  state_d;
  jhdp_pkg::state_t  step_nxt;
  jhdp_pkg::status_e step_status;
  logic              in_fire;
  logic              out_valid_q;
  logic              out_valid_d;
  logic [15:0]       height_q;
  logic [15:0]       width_q;
  logic              found_q;
  jhdp_pkg::status_e status_q;

  jhdp_step u_step (
    .cur_i    (state_q),
    .byte_i   (data_byte_i),
    .nxt_o    (step_nxt),
    .status_o (step_status)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      if (last_i) begin
        state_d     = jhdp_pkg::StateReset;
        out_valid_d = 1'b1;
      end else begin
        state_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jhdp_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_i) begin
      height_q <= step_nxt.height;
      width_q  <= step_nxt.width;
      found_q  <= step_nxt.found;
      status_q <= step_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign height_o      = height_q;
  assign width_o       = width_q;
  assign frame_found_o = found_q;
  assign status_o      = status_q;

  `ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni, out_valid_o && !out_ready_i,
               !in_ready_o, "Input accepted while a result item is stalled.")
  `ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, in_fire && last_i,
               out_valid_o, "Last byte did not produce a result item.")
  `ASSERT_NEXT(a_last_restarts, clk_i, rst_ni, in_fire && last_i,
               state_q.phase == jhdp_pkg::PH_START0, "Parser did not restart after last byte.")
  `ASSERT_SAME(a_stop_has_error, clk_i, rst_ni, state_q.phase == jhdp_pkg::PH_STOP,
               state_q.err != jhdp_pkg::ST_OK, "Parser stopped without an error code.")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [15:0]       height;
    logic [15:0]       width;
    logic              found;
    jhdp_pkg::status_e status;
  } dims_t;

  // Start-of-frame markers are FFC0..FFCF except the table and reserved codes.
  function automatic bit is_sof_code(input logic [15:0] m);
    return (m[15:4] == 12'hFFC) && (m[3:0] != 4'h4) && (m[3:0] != 4'h8);
  endfunction

  class dim_scoreboard;
    jhdp_pkg::phase_e  ph;
    logic [15:0]       marker;
    logic [15:0]       remain;
    logic [2:0]        pos;
    logic [15:0]       height;
    logic [15:0]       width;
    logic              found;
    jhdp_pkg::status_e err;
    logic              frame;
    logic [15:0]       pend_h;
    logic [15:0]       pend_w;
    dims_t             expected_dims[$];
    int                mismatches;
    int                checked;
    int                status_seen[4];

    function new();
      clear_parse();
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void clear_parse();
      ph = jhdp_pkg::PH_START0;
      marker = '0;
      remain = '0;
      pos = '0;
      height = '0;
      width = '0;
      found = 1'b0;
      err = jhdp_pkg::ST_OK;
      frame = 1'b0;
      pend_h = '0;
      pend_w = '0;
    endfunction

    function void stop_on(input jhdp_pkg::status_e code);
      err = code;
      ph = jhdp_pkg::PH_STOP;
    endfunction

    function void note_byte(input logic [7:0] b, input logic l);
      jhdp_pkg::status_e end_st;
      logic [15:0]       len;
      dims_t             d;
      end_st = jhdp_pkg::ST_OK;
      case (ph)
        jhdp_pkg::PH_START0: begin
          if (b != jhdp_pkg::SoiByte0) begin
            stop_on(jhdp_pkg::ST_NO_SOI);
          end else begin
            ph = jhdp_pkg::PH_START1;
            end_st = jhdp_pkg::ST_NO_SOI;
          end
        end
        jhdp_pkg::PH_START1: begin
          if (b != jhdp_pkg::SoiByte1) stop_on(jhdp_pkg::ST_NO_SOI);
          else ph = jhdp_pkg::PH_MARKHI;
        end
        jhdp_pkg::PH_MARKHI: begin
          marker = {b, 8'h00};
          ph = jhdp_pkg::PH_MARKLO;
          end_st = jhdp_pkg::ST_TRUNCATED;
        end
        jhdp_pkg::PH_MARKLO: begin
          marker[7:0] = b;
          ph = jhdp_pkg::PH_LENHI;
          end_st = jhdp_pkg::ST_TRUNCATED;
        end
        jhdp_pkg::PH_LENHI: begin
          remain = {b, 8'h00};
          ph = jhdp_pkg::PH_LENLO;
          end_st = jhdp_pkg::ST_TRUNCATED;
        end
        jhdp_pkg::PH_LENLO: begin
          len = {remain[15:8], b};
          frame = is_sof_code(marker);
          if (len < jhdp_pkg::MinLength) begin
            stop_on(jhdp_pkg::ST_MALFORMED);
          end else if (frame && len < jhdp_pkg::MinSofLength) begin
            stop_on(jhdp_pkg::ST_MALFORMED);
          end else begin
            remain = len - 16'd2;
            pos = '0;
            if (remain == 16'd0) begin
              ph = jhdp_pkg::PH_MARKHI;
            end else begin
              ph = jhdp_pkg::PH_PAYLOAD;
              if (frame) end_st = jhdp_pkg::ST_TRUNCATED;
            end
          end
        end
        jhdp_pkg::PH_PAYLOAD: begin
          if (frame && pos < jhdp_pkg::PosSat) begin
            case (pos)
              3'd1: pend_h[15:8] = b;
              3'd2: pend_h[7:0] = b;
              3'd3: pend_w[15:8] = b;
              3'd4: begin
                pend_w[7:0] = b;
                height = pend_h;
                width = {pend_w[15:8], b};
                found = 1'b1;
              end
              default: ;
            endcase
            if (pos < 3'd4) end_st = jhdp_pkg::ST_TRUNCATED;
          end
          if (pos < jhdp_pkg::PosSat) pos = pos + 3'd1;
          remain = remain - 16'd1;
          if (remain == 16'd0) ph = jhdp_pkg::PH_MARKHI;
        end
        default: ;
      endcase
      if (l) begin
        d.height = height;
        d.width = width;
        d.found = found;
        d.status = (err != jhdp_pkg::ST_OK) ? err : end_st;
        expected_dims.push_back(d);
        clear_parse();
      end
    endfunction

    task report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(input logic [15:0] h, input logic [15:0] w, input logic f,
                      input logic [1:0] s);
      dims_t d;
      if (expected_dims.size() == 0) begin
        report($sformatf("result h=%h w=%h f=%b s=%0d with nothing pending", h, w, f, s));
      end else begin
        d = expected_dims.pop_front();
        checked++;
        status_seen[d.status]++;
        if (h !== d.height) report($sformatf("height %h, predicted %h", h, d.height));
        if (w !== d.width) report($sformatf("width %h, predicted %h", w, d.width));
        if (f !== d.found) report($sformatf("frame_found %b, predicted %b", f, d.found));
        if (s !== d.status) report($sformatf("status %0d, predicted %0d", s, d.status));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] height_o;
  logic [15:0] width_o;
  logic        frame_found_o;
  logic [1:0]  status_o;

  jpeg_header_dimension_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .height_o     (height_o),
    .width_o      (width_o),
    .frame_found_o(frame_found_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dim_scoreboard sb;
  logic [7:0]    stream_q[$];
  int            burst_left = 0;
  int            bytes_sent = 0;
  int            streams_sent = 0;
  int            stall_cnt = 0;
  int            stall_mode = 0;

  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null && out_valid_o && out_ready_i) begin
      sb.check_result(height_o, width_o, frame_found_o, status_o);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b, l);
    bytes_sent++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    streams_sent++;
  endtask

  function automatic void add_segment();
    logic [15:0] m;
    logic [15:0] len;
    int          r;
    r = $urandom_range(0, 9);
    if (r <= 3) m = {12'hFFC, 4'($urandom_range(0, 15))};
    else if (r == 4) m = jhdp_pkg::DhtMarker;
    else if (r == 5) m = jhdp_pkg::JpgMarker;
    else if (r <= 7) m = {8'hFF, 8'($urandom_range(0, 255))};
    else if (r == 8) m = 16'($urandom_range(0, 65535));
    else m = 16'hFFE0;
    r = $urandom_range(0, 19);
    if (r == 0) len = 16'($urandom_range(0, 1));
    else if (r == 1) len = is_sof_code(m) ? 16'($urandom_range(2, 6)) : 16'd2;
    else if (r == 2 && $urandom_range(0, 4) == 0) len = 16'($urandom_range(256, 300));
    else len = is_sof_code(m) ? 16'($urandom_range(7, 14)) : 16'($urandom_range(2, 10));
    stream_q.push_back(m[15:8]);
    stream_q.push_back(m[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    for (int i = 2; i < len && i < 400; i++) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_stream();
    int cut;
    stream_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      stream_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                      : jhdp_pkg::SoiByte0);
      stream_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                      : jhdp_pkg::SoiByte1);
      repeat ($urandom_range(0, 4)) add_segment();
      if ($urandom_range(0, 9) < 3) begin
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'hD9);
      end
      if ($urandom_range(0, 99) < 35) begin
        cut = $urandom_range(1, stream_q.size());
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
    end
  endfunction

  initial begin
    int wait_cycles;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stream_q = {8'h00};
    send_stream();
    stream_q = {8'hFF};
    send_stream();
    stream_q = {8'hFF, 8'hD8};
    send_stream();
    stream_q = {8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                8'hFF};
    send_stream();
    stream_q = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01};
    send_stream();
    stream_q = {8'hFF, 8'h12, 8'h00};
    send_stream();

    while (bytes_sent < 1150 || streams_sent < 46) begin
      build_stream();
      send_stream();
    end
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
    end

    wait_cycles = 0;
    while (sb.expected_dims.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.expected_dims.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_dims.size()));
    end

    $display("Sent %0d streams (%0d bytes), checked %0d results, %0d mismatches",
             streams_sent, bytes_sent, sb.checked, sb.mismatches);
    $display("Statuses seen: ok %0d, no start %0d, malformed %0d, truncated %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with results still outstanding");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/jhdp_pkg.sv
src/jhdp_step.sv
src/jpeg_header_dimension_parser_unit.sv
verif/tb.sv
